// File: design/skvt_pkg.sv
// Package for the sorted key/value table: opcodes, status codes, order modes
// and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package skvt_pkg;
  localparam int DEF_DEPTH     = 256;
  localparam int DEF_KEY_BITS  = 32;
  localparam int DEF_DATA_BITS = 32;

  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_LOOKUP     = 3'd1;
  localparam logic [2:0] OP_FIND_FIRST = 3'd2;
  localparam logic [2:0] OP_FIND_NEXT  = 3'd3;
  localparam logic [2:0] OP_DEL_RANGE  = 3'd4;
  localparam logic [2:0] OP_DEL_LAST   = 3'd5;
  localparam logic [2:0] OP_REPLACE    = 3'd6;
  localparam logic [2:0] OP_CLEAR      = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  localparam logic [1:0] MODE_ASC   = 2'd0;
  localparam logic [1:0] MODE_DESC  = 2'd1;
  localparam logic [1:0] MODE_FRONT = 2'd2;
  localparam logic [1:0] MODE_BACK  = 2'd3;
endpackage
`default_nettype wire

// File: design/skvt_cmp.sv
// Shared key compare unit of the sorted key/value table: gives the ordering of
// a stored key against the probe key under the current order mode. Uses skvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skvt_cmp #(
  parameter int KEY_BITS = skvt_pkg::DEF_KEY_BITS
) (
  input  wire logic [1:0]          mode,
  input  wire logic [KEY_BITS-1:0] stored,
  input  wire logic [KEY_BITS-1:0] probe,
  output logic                     eq,
  output logic                     gt
);
  // gt means the stored key sorts after the probe key.
  always_comb begin
    eq = 1'b0;
    gt = 1'b0;
    case (mode)
      skvt_pkg::MODE_ASC: begin
        eq = (stored == probe);
        gt = (stored > probe);
      end
      skvt_pkg::MODE_DESC: begin
        eq = (stored == probe);
        gt = (stored < probe);
      end
      skvt_pkg::MODE_FRONT: gt = 1'b1;
      default: gt = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

// File: design/sorted_key_value_table_top.sv
// Top level of the sorted key/value table: sequencer, entry memories and
// cursor. Uses skvt_pkg and skvt_cmp.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   A transaction is taken when start is high and busy is low. The block
//   then raises busy and works on it alone; one result appears on the out_
//   ports for one cycle with out_valid high, and busy drops with it.
//   cfg_we writes order_mode (0 ascending, 1 descending, 2 front, 3 back);
//   write it only while idle.
//   Memory: reads go through a single registered read port, one read per
//   cycle, beside one write port; one key compare unit is shared by all steps.
//   Each binary search probe reads a key, waits for the registered data and
//   then compares it. Insert moves entries one at a time over the span that
//   shifts; delete_range moves the same way. Replace first closes its slot
//   and then opens the new one. Find_first walks back over each equal key
//   it passes; clear, delete_last and find_next run no binary search.
//   Reset clears the count, cursor and order mode; the memories need no
//   clearing since entries are read only after they were written.
//   The receiver cannot stall: each result is taken in its strobe cycle.
module sorted_key_value_table_top #(
  parameter int TABLE_DEPTH = skvt_pkg::DEF_DEPTH,
  parameter int KEY_BITS    = skvt_pkg::DEF_KEY_BITS,
  parameter int DATA_BITS   = skvt_pkg::DEF_DATA_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_order_mode,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_payload,
  input  wire logic [7:0]  in_position,
  input  wire logic [8:0]  in_amount,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic             out_found,
  output logic [8:0]       out_result_index,
  output logic [31:0]      out_result_key,
  output logic [31:0]      out_result_data,
  output logic [8:0]       out_entry_count
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SRCH_INIT, S_SRCH_RD, S_SRCH_WAIT, S_SRCH_CMP,
    S_LO_RD, S_LO_WAIT, S_LO_CMP, S_HI_RD, S_HI_WAIT, S_HI_CMP,
    S_AFTER, S_WALK_RD, S_WALK_WAIT, S_WALK_CMP, S_FETCH_RD, S_FETCH_WAIT,
    S_OPEN_RD, S_OPEN_WR, S_REM_RD, S_REM_WR, S_NEXT_RD, S_NEXT_WAIT,
    S_NEXT_CMP, S_WRITE, S_DONE
  } state_t;

  state_t state_r;
  logic [1:0]           mode_r;
  logic [2:0]           op_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [DATA_BITS-1:0] data_r;
  logic [CW-1:0]        pos_r, amt_r, count_r, n_r;
  logic [CW-1:0]        lo_r, hi_r, mid_r, i_r;
  logic                 hit_r;
  logic [CW-1:0]        cur_idx_r;
  logic [KEY_BITS-1:0]  cur_key_r;
  logic                 cur_live_r;
  logic [1:0]           st_r;
  logic [CW-1:0]        idx_r;

  // Entry memories: one address per cycle, registered read data.
  logic [KEY_BITS-1:0]  key_mem  [TABLE_DEPTH];
  logic [DATA_BITS-1:0] data_mem [TABLE_DEPTH];
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 wr_en;
  logic [KEY_BITS-1:0]  wr_key, rd_key_r;
  logic [DATA_BITS-1:0] wr_data, rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      data_mem[wr_addr] <= wr_data;
    end
    rd_key_r  <= key_mem[rd_addr];
    rd_data_r <= data_mem[rd_addr];
  end

  // Shared compare: memory key against the search key, or the cursor key for find_next.
  logic [KEY_BITS-1:0] probe;
  logic c_eq, c_gt;
  assign probe = (state_r == S_NEXT_CMP) ? cur_key_r : key_r;
  skvt_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
    .mode(mode_r), .stored(rd_key_r), .probe(probe), .eq(c_eq), .gt(c_gt)
  );

  // Read address and write port selection by state. The address is held
  // through each wait state so the registered data still belongs to it.
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_key  = rd_key_r;
    wr_data = rd_data_r;
    case (state_r)
      S_SRCH_RD, S_SRCH_WAIT:   rd_addr = mid_r[AW-1:0];
      S_LO_RD, S_LO_WAIT:       rd_addr = lo_r[AW-1:0];
      S_HI_RD, S_HI_WAIT:       rd_addr = hi_r[AW-1:0];
      S_WALK_RD, S_WALK_WAIT:   rd_addr = AW'(idx_r - 1'b1);
      S_FETCH_RD, S_FETCH_WAIT: rd_addr = idx_r[AW-1:0];
      S_NEXT_RD, S_NEXT_WAIT, S_NEXT_CMP: rd_addr = AW'(cur_idx_r + 1'b1);
      S_OPEN_RD:  rd_addr = AW'(i_r - 1'b1);
      S_REM_RD:   rd_addr = AW'(i_r + amt_r);
      S_OPEN_WR, S_REM_WR: begin
        wr_en   = 1'b1;
        wr_addr = i_r[AW-1:0];
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_key  = key_r;
        wr_data = data_r;
      end
      default: rd_addr = '0;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // Sequencer, cursor and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mode_r     <= skvt_pkg::MODE_ASC;
      count_r    <= '0;
      cur_live_r <= 1'b0;
      cur_idx_r  <= '0;
      cur_key_r  <= '1;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) mode_r <= cfg_order_mode;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r   <= in_opcode;
            key_r  <= KEY_BITS'(in_key);
            data_r <= DATA_BITS'(in_payload);
            pos_r  <= CW'(in_position);
            amt_r  <= CW'(in_amount);
            st_r   <= skvt_pkg::ST_OK;
            hit_r  <= 1'b0;
            idx_r  <= '0;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          n_r <= count_r;
          case (op_r)
            skvt_pkg::OP_INSERT, skvt_pkg::OP_LOOKUP, skvt_pkg::OP_FIND_FIRST:
              state_r <= S_SRCH_INIT;
            skvt_pkg::OP_FIND_NEXT: begin
              if (!cur_live_r || (cur_idx_r + 1'b1) >= count_r) begin
                st_r <= skvt_pkg::ST_NOTFOUND;
                cur_live_r <= 1'b0;
                cur_idx_r  <= '0;
                cur_key_r  <= '1;
                state_r <= S_DONE;
              end else begin
                state_r <= S_NEXT_RD;
              end
            end
            skvt_pkg::OP_DEL_RANGE: begin
              // The end of the span is checked one bit wider so it cannot wrap.
              if (pos_r >= count_r ||
                  ({1'b0, pos_r} + {1'b0, amt_r}) > {1'b0, count_r}) begin
                st_r <= skvt_pkg::ST_BAD;
                state_r <= S_DONE;
              end else begin
                idx_r <= pos_r;
                i_r   <= pos_r;
                state_r <= S_REM_RD;
              end
            end
            skvt_pkg::OP_DEL_LAST: begin
              if (amt_r > count_r) st_r <= skvt_pkg::ST_BAD;
              else count_r <= count_r - amt_r;
              state_r <= S_DONE;
            end
            skvt_pkg::OP_REPLACE: begin
              if (pos_r >= count_r) begin
                st_r <= skvt_pkg::ST_BAD;
                state_r <= S_DONE;
              end else begin
                i_r   <= pos_r;
                amt_r <= CW'(1);
                state_r <= S_REM_RD;
              end
            end
            default: begin
              count_r    <= '0;
              cur_live_r <= 1'b0;
              cur_idx_r  <= '0;
              cur_key_r  <= '1;
              state_r <= S_DONE;
            end
          endcase
        end
        // Binary search over entries 0..n_r-1.
        S_SRCH_INIT: begin
          lo_r <= '0;
          hi_r <= n_r - 1'b1;
          if (n_r == '0) begin
            idx_r <= '0;
            state_r <= S_AFTER;
          end else if (n_r > CW'(2)) begin
            mid_r <= (n_r - 1'b1) >> 1;
            state_r <= S_SRCH_RD;
          end else begin
            state_r <= S_LO_RD;
          end
        end
        S_SRCH_RD:   state_r <= S_SRCH_WAIT;
        S_SRCH_WAIT: state_r <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          if (c_eq) begin
            hit_r <= 1'b1;
            idx_r <= mid_r;
            state_r <= S_AFTER;
          end else begin
            if (c_gt) begin
              hi_r <= mid_r;
              if (mid_r > lo_r + 1'b1) begin
                mid_r <= lo_r + ((mid_r - lo_r) >> 1);
                state_r <= S_SRCH_RD;
              end else state_r <= S_LO_RD;
            end else begin
              lo_r <= mid_r;
              if (hi_r > mid_r + 1'b1) begin
                mid_r <= mid_r + ((hi_r - mid_r) >> 1);
                state_r <= S_SRCH_RD;
              end else state_r <= S_LO_RD;
            end
          end
        end
        S_LO_RD:   state_r <= S_LO_WAIT;
        S_LO_WAIT: state_r <= S_LO_CMP;
        S_LO_CMP: begin
          if (c_eq || c_gt) begin
            hit_r <= c_eq;
            idx_r <= lo_r;
            state_r <= S_AFTER;
          end else state_r <= S_HI_RD;
        end
        S_HI_RD:   state_r <= S_HI_WAIT;
        S_HI_WAIT: state_r <= S_HI_CMP;
        S_HI_CMP: begin
          hit_r <= c_eq;
          idx_r <= (c_eq || c_gt) ? hi_r : hi_r + 1'b1;
          state_r <= S_AFTER;
        end
        // Act on the search result per opcode.
        S_AFTER: begin
          case (op_r)
            skvt_pkg::OP_INSERT: begin
              if (count_r >= DEPTH_C) begin
                st_r <= skvt_pkg::ST_FULL;
                state_r <= S_DONE;
              end else begin
                i_r <= count_r;
                count_r <= count_r + 1'b1;
                state_r <= S_OPEN_RD;
              end
            end
            skvt_pkg::OP_REPLACE: begin
              i_r <= n_r;
              state_r <= S_OPEN_RD;
            end
            skvt_pkg::OP_LOOKUP: begin
              if (hit_r) state_r <= S_FETCH_RD;
              else begin
                st_r <= skvt_pkg::ST_NOTFOUND;
                state_r <= S_DONE;
              end
            end
            default: begin
              if (hit_r) state_r <= S_WALK_RD;
              else begin
                st_r <= skvt_pkg::ST_NOTFOUND;
                cur_live_r <= 1'b0;
                cur_idx_r  <= '0;
                cur_key_r  <= '1;
                state_r <= S_DONE;
              end
            end
          endcase
        end
        // Walk back to the first equal key.
        S_WALK_RD: begin
          if (idx_r == '0) state_r <= S_FETCH_RD;
          else state_r <= S_WALK_WAIT;
        end
        S_WALK_WAIT: state_r <= S_WALK_CMP;
        S_WALK_CMP: begin
          if (c_eq) begin
            idx_r <= idx_r - 1'b1;
            state_r <= S_WALK_RD;
          end else state_r <= S_FETCH_RD;
        end
        S_FETCH_RD: begin
          if (op_r == skvt_pkg::OP_FIND_FIRST) begin
            cur_live_r <= 1'b1;
            cur_idx_r  <= idx_r;
            cur_key_r  <= key_r;
          end
          state_r <= S_FETCH_WAIT;
        end
        S_FETCH_WAIT: state_r <= S_DONE;
        // Shift entries up to open a slot at idx_r.
        S_OPEN_RD: begin
          if (i_r > idx_r) state_r <= S_OPEN_WR;
          else state_r <= S_WRITE;
        end
        S_OPEN_WR: begin
          i_r <= i_r - 1'b1;
          state_r <= S_OPEN_RD;
        end
        // Close a span of amt_r entries at i_r.
        S_REM_RD: begin
          if ((i_r + amt_r) < count_r) state_r <= S_REM_WR;
          else if (op_r == skvt_pkg::OP_REPLACE) begin
            n_r <= count_r - 1'b1;
            state_r <= S_SRCH_INIT;
          end else begin
            count_r <= count_r - amt_r;
            state_r <= S_DONE;
          end
        end
        S_REM_WR: begin
          i_r <= i_r + 1'b1;
          state_r <= S_REM_RD;
        end
        S_NEXT_RD:   state_r <= S_NEXT_WAIT;
        S_NEXT_WAIT: state_r <= S_NEXT_CMP;
        S_NEXT_CMP: begin
          if (c_eq) begin
            cur_idx_r <= cur_idx_r + 1'b1;
            idx_r <= cur_idx_r + 1'b1;
            hit_r <= 1'b1;
          end else begin
            st_r <= skvt_pkg::ST_NOTFOUND;
            cur_live_r <= 1'b0;
            cur_idx_r  <= '0;
            cur_key_r  <= '1;
          end
          state_r <= S_DONE;
        end
        S_WRITE: state_r <= S_DONE;
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_DONE) begin
        out_valid <= 1'b1;
        state_r   <= S_IDLE;
      end
    end
  end

  // Result fields; the memory read data is live in the cycle of S_DONE.
  logic show_mem, show_new;
  always_comb begin
    show_mem = (st_r == skvt_pkg::ST_OK) &&
               (op_r == skvt_pkg::OP_LOOKUP || op_r == skvt_pkg::OP_FIND_FIRST ||
                op_r == skvt_pkg::OP_FIND_NEXT);
    show_new = (st_r == skvt_pkg::ST_OK) &&
               (op_r == skvt_pkg::OP_INSERT || op_r == skvt_pkg::OP_REPLACE);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_status       <= st_r;
      out_found        <= hit_r && (st_r != skvt_pkg::ST_BAD) &&
                          (op_r != skvt_pkg::OP_DEL_RANGE) &&
                          (op_r != skvt_pkg::OP_DEL_LAST) &&
                          (op_r != skvt_pkg::OP_CLEAR);
      out_result_index <= (op_r == skvt_pkg::OP_FIND_NEXT && st_r != skvt_pkg::ST_OK)
                          ? 9'd0 : 9'(idx_r);
      out_entry_count  <= 9'(count_r);
      if (show_mem) begin
        out_result_key  <= 32'(rd_key_r);
        out_result_data <= 32'(rd_data_r);
      end else if (show_new) begin
        out_result_key  <= 32'(key_r);
        out_result_data <= 32'(data_r);
      end else begin
        out_result_key  <= '0;
        out_result_data <= '0;
      end
    end
  end
endmodule
`default_nettype wire
